/* hw/rtl/kwmoq_pkg.sv */
// Shared types, codes and field layout for the k-way merge ordering queue.
`default_nettype none

package kwmoq_pkg;

    localparam int MAX_SOURCES_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;

    localparam int ID_W        = 4;
    localparam int STAMP_W     = 32;
    localparam int OCC_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam int IN_ID_LSB    = 0;
    localparam int IN_STAMP_LSB = IN_ID_LSB + ID_W;
    localparam int IN_MORE_BIT  = IN_STAMP_LSB + STAMP_W;

    localparam int OUT_VALID_BIT  = 0;
    localparam int OUT_ID_LSB     = OUT_VALID_BIT + 1;
    localparam int OUT_STAMP_LSB  = OUT_ID_LSB + ID_W;
    localparam int OUT_OCC_LSB    = OUT_STAMP_LSB + STAMP_W;
    localparam int OUT_STATUS_LSB = OUT_OCC_LSB + OCC_W;
    localparam int OUT_USED_W     = OUT_STATUS_LSB + STATUS_W;

    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic    load;
        logic    drop;
        logic    insert;
        logic    report;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic more;
    } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/k_way_merge_ordering_queue_core.sv */
// Top level of the k-way merge ordering queue.
//
//  channel | dir | tdata fields (lsb first)                          | tuser
//  s_axis  | in  | source_id[3:0] stamp[35:4] has_more[36]           | cmd
//  m_axis  | out | head_valid[0] head_source[4:1] head_stamp[36:5]   | -
//          |     | occupancy[41:37] status[43:42]                    |
//
// Insert goes through insert and report; advance through drop, then insert
// on reinsertion, then report; a dropped insert or an advance on an empty
// queue goes straight to report. s_tready rises as the result is loaded.
// A full result waits in the output register while the next transaction is
// accepted; the step that loads it stalls until that register is free.
// Reset clears the fill count and control; stored keys need no clearing.
`default_nettype none

module k_way_merge_ordering_queue_core #(
    parameter int MAX_SOURCES = kwmoq_pkg::MAX_SOURCES_DEF,
    parameter int KEY_BITS    = kwmoq_pkg::KEY_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // source_id, stamp, has_more
    input  wire logic [kwmoq_pkg::IN_TDATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic                              s_tuser,
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // head_valid, head_source, head_stamp, occupancy, status
    output      logic [kwmoq_pkg::OUT_TDATA_W-1:0] m_tdata
);

    kwmoq_pkg::dp_cmd_t  dp_cmd;
    kwmoq_pkg::dp_stat_t dp_stat;

    kwmoq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    kwmoq_dpath #(
        .MAX_SOURCES (MAX_SOURCES),
        .KEY_BITS    (KEY_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_id     (s_tdata[kwmoq_pkg::IN_ID_LSB +: kwmoq_pkg::ID_W]),
        .in_stamp  (s_tdata[kwmoq_pkg::IN_STAMP_LSB +: kwmoq_pkg::STAMP_W]),
        .in_more   (s_tdata[kwmoq_pkg::IN_MORE_BIT]),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .out_tdata (m_tdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/kwmoq_ctrl.sv */
// Sequencing state machine for the merge ordering queue.
`default_nettype none

module kwmoq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_tuser,
    output      logic                s_tready,
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      kwmoq_pkg::dp_cmd_t  cmd,
    input  wire kwmoq_pkg::dp_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DROP,
        S_INSERT,
        S_REPORT
    } state_t;

    state_t             state_reg, state_next;
    kwmoq_pkg::status_t status_reg, status_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               accept;
    logic               out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.load      = 1'b0;
        cmd.drop      = 1'b0;
        cmd.insert    = 1'b0;
        cmd.report    = 1'b0;
        cmd.status    = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load    = 1'b1;
                    status_next = kwmoq_pkg::ST_DONE;
                    if (kwmoq_pkg::cmd_t'(s_tuser) == kwmoq_pkg::CMD_ADVANCE)
                    begin
                        if (stat.empty)
                        begin
                            status_next = kwmoq_pkg::ST_EMPTY;
                            state_next  = S_REPORT;
                        end
                        else
                        begin
                            state_next = S_DROP;
                        end
                    end
                    else if (stat.full)
                    begin
                        status_next = kwmoq_pkg::ST_FULL;
                        state_next  = S_REPORT;
                    end
                    else
                    begin
                        state_next = S_INSERT;
                    end
                end
            end
            S_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = stat.more ? S_INSERT : S_REPORT;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    cmd.report    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            status_reg   <= kwmoq_pkg::ST_DONE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/kwmoq_dpath.sv */
// Sorted cell row, fill count and result register of the merge ordering queue.
`default_nettype none

module kwmoq_dpath #(
    parameter int MAX_SOURCES = kwmoq_pkg::MAX_SOURCES_DEF,
    parameter int KEY_BITS    = kwmoq_pkg::KEY_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [kwmoq_pkg::ID_W-1:0]            in_id,
    input  wire logic [kwmoq_pkg::STAMP_W-1:0]         in_stamp,
    input  wire logic                                  in_more,
    input  wire kwmoq_pkg::dp_cmd_t                    cmd,
    output      kwmoq_pkg::dp_stat_t                   stat,
    output      logic [kwmoq_pkg::OUT_TDATA_W-1:0]     out_tdata
);

    localparam int CNT_W = $clog2(MAX_SOURCES + 1);

    logic [KEY_BITS-1:0]       key_reg  [MAX_SOURCES];
    logic [KEY_BITS-1:0]       key_next [MAX_SOURCES];
    logic [kwmoq_pkg::ID_W-1:0] id_reg  [MAX_SOURCES];
    logic [kwmoq_pkg::ID_W-1:0] id_next [MAX_SOURCES];
    logic [MAX_SOURCES-1:0]    gt;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [KEY_BITS-1:0]       new_key_reg;
    logic [kwmoq_pkg::ID_W-1:0] new_id_reg;
    logic                      more_reg;
    logic [kwmoq_pkg::OUT_TDATA_W-1:0] out_reg;
    logic                      nonempty;
    logic [kwmoq_pkg::ID_W-1:0]    head_id;
    logic [kwmoq_pkg::STAMP_W-1:0] head_stamp;

    assign nonempty   = (fill_reg != '0);
    assign stat.empty = !nonempty;
    assign stat.full  = (fill_reg == CNT_W'(MAX_SOURCES));
    assign stat.more  = more_reg;
    assign head_id    = nonempty ? id_reg[0] : '0;
    assign head_stamp = nonempty ? kwmoq_pkg::STAMP_W'(key_reg[0]) : '0;
    assign out_tdata  = out_reg;

    for (genvar i = 0; i < MAX_SOURCES; i++)
    begin : g_cell
        assign gt[i] = (CNT_W'(i) < fill_reg) && (key_reg[i] > new_key_reg);

        always_comb
        begin
            key_next[i] = key_reg[i];
            id_next[i]  = id_reg[i];
            if (cmd.drop)
            begin
                if (i < MAX_SOURCES - 1)
                begin
                    key_next[i] = key_reg[(i < MAX_SOURCES - 1) ? i + 1 : i];
                    id_next[i]  = id_reg[(i < MAX_SOURCES - 1) ? i + 1 : i];
                end
            end
            else if (cmd.insert)
            begin
                if ((i > 0) && gt[(i > 0) ? i - 1 : i])
                begin
                    key_next[i] = key_reg[(i > 0) ? i - 1 : i];
                    id_next[i]  = id_reg[(i > 0) ? i - 1 : i];
                end
                else if (gt[i] || (CNT_W'(i) == fill_reg))
                begin
                    key_next[i] = new_key_reg;
                    id_next[i]  = new_id_reg;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            key_reg[i] <= key_next[i];
            id_reg[i]  <= id_next[i];
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.drop)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        else if (cmd.insert)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            new_key_reg <= KEY_BITS'(in_stamp);
            new_id_reg  <= in_id;
            more_reg    <= in_more;
        end
        if (cmd.drop)
        begin
            new_id_reg <= id_reg[0];
        end
        if (cmd.report)
        begin
            out_reg <= kwmoq_pkg::OUT_TDATA_W'({cmd.status,
                                                kwmoq_pkg::OCC_W'(fill_reg),
                                                head_stamp,
                                                head_id,
                                                nonempty});
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/kwmoq_checker.sv */
// Port-level checks of the merge ordering queue and their binding.
`default_nettype none

module kwmoq_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [kwmoq_pkg::IN_TDATA_W-1:0]  s_tdata,
    input wire logic                              s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [kwmoq_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic [kwmoq_pkg::STATUS_W-1:0] st;
    logic [kwmoq_pkg::OCC_W-1:0]    occ;
    logic                           hv;

    assign st  = m_tdata[kwmoq_pkg::OUT_STATUS_LSB +: kwmoq_pkg::STATUS_W];
    assign occ = m_tdata[kwmoq_pkg::OUT_OCC_LSB +: kwmoq_pkg::OCC_W];
    assign hv  = m_tdata[kwmoq_pkg::OUT_VALID_BIT];

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a transaction is in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (st == kwmoq_pkg::ST_EMPTY)) |-> (!hv && (occ == '0)))
        else $error("advance on empty reported a nonempty queue");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (st == kwmoq_pkg::ST_FULL)) |-> hv)
        else $error("dropped insert reported an empty queue");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((st == kwmoq_pkg::ST_DONE) || (st == kwmoq_pkg::ST_FULL)
                      || (st == kwmoq_pkg::ST_EMPTY)))
        else $error("undefined status code");

endmodule

bind k_way_merge_ordering_queue_core kwmoq_checker u_kwmoq_checker (.*);

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the k-way merge ordering queue core.
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH          = kwmoq_pkg::MAX_SOURCES_DEF;
    localparam int ID_W           = kwmoq_pkg::ID_W;
    localparam int STAMP_W        = kwmoq_pkg::STAMP_W;
    localparam int OCC_W          = kwmoq_pkg::OCC_W;
    localparam int STATUS_W       = kwmoq_pkg::STATUS_W;
    localparam int IN_TDATA_W     = kwmoq_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W    = kwmoq_pkg::OUT_TDATA_W;
    localparam int IN_ID_LSB      = kwmoq_pkg::IN_ID_LSB;
    localparam int IN_STAMP_LSB   = kwmoq_pkg::IN_STAMP_LSB;
    localparam int IN_MORE_BIT    = kwmoq_pkg::IN_MORE_BIT;
    localparam int OUT_VALID_BIT  = kwmoq_pkg::OUT_VALID_BIT;
    localparam int OUT_ID_LSB     = kwmoq_pkg::OUT_ID_LSB;
    localparam int OUT_STAMP_LSB  = kwmoq_pkg::OUT_STAMP_LSB;
    localparam int OUT_OCC_LSB    = kwmoq_pkg::OUT_OCC_LSB;
    localparam int OUT_STATUS_LSB = kwmoq_pkg::OUT_STATUS_LSB;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    source;
        logic [STAMP_W-1:0] stamp;
        logic [OCC_W-1:0]   occ;
        kwmoq_pkg::status_t status;
    } head_rpt_t;

    typedef struct {
        kwmoq_pkg::cmd_t    cmd;
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
        logic               more;
        bit                 typed;
        head_rpt_t          want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [STAMP_W-1:0] key_mirror [DEPTH];
    logic [ID_W-1:0]    id_mirror [DEPTH];
    int                 held = 0;

    head_rpt_t head_expect_q [$];
    stim_row_t stim_rows [$];
    bit        idling_on = 1'b1;
    int        stall_left = 0;
    int        fail_count = 0;
    int        mismatch_count = 0;
    int        n_insert = 0;
    int        n_advance = 0;
    int        n_full_drop = 0;
    int        n_empty_adv = 0;
    int        n_results = 0;

    k_way_merge_ordering_queue_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void place_source(logic [STAMP_W-1:0] key, logic [ID_W-1:0] id);
        int pos;
        pos = held;
        while (pos > 0 && key_mirror[pos-1] > key)
        begin
            key_mirror[pos] = key_mirror[pos-1];
            id_mirror[pos]  = id_mirror[pos-1];
            pos--;
        end
        key_mirror[pos] = key;
        id_mirror[pos]  = id;
        held++;
    endfunction

    function automatic head_rpt_t order_step(kwmoq_pkg::cmd_t cmd, logic [ID_W-1:0] id,
                                             logic [STAMP_W-1:0] stamp, logic more);
        head_rpt_t       r;
        logic [ID_W-1:0] head_id;
        r.status = kwmoq_pkg::ST_DONE;
        if (cmd == kwmoq_pkg::CMD_INSERT)
        begin
            n_insert++;
            if (held >= DEPTH)
            begin
                r.status = kwmoq_pkg::ST_FULL;
                n_full_drop++;
            end
            else
                place_source(stamp, id);
        end
        else
        begin
            n_advance++;
            if (held == 0)
            begin
                r.status = kwmoq_pkg::ST_EMPTY;
                n_empty_adv++;
            end
            else
            begin
                head_id = id_mirror[0];
                for (int i = 1; i < held; i++)
                begin
                    key_mirror[i-1] = key_mirror[i];
                    id_mirror[i-1]  = id_mirror[i];
                end
                held--;
                if (more)
                    place_source(stamp, head_id);
            end
        end
        r.valid  = (held > 0);
        r.source = (held > 0) ? id_mirror[0] : '0;
        r.stamp  = (held > 0) ? key_mirror[0] : '0;
        r.occ    = OCC_W'(held);
        return r;
    endfunction

    function automatic void add_row(kwmoq_pkg::cmd_t cmd, logic [ID_W-1:0] id,
                                    logic [STAMP_W-1:0] stamp, logic more, bit typed,
                                    head_rpt_t want);
        stim_row_t row;
        row.cmd   = cmd;
        row.id    = id;
        row.stamp = stamp;
        row.more  = more;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endfunction

    task automatic send_cmd(kwmoq_pkg::cmd_t cmd, logic [ID_W-1:0] id,
                            logic [STAMP_W-1:0] stamp, logic more, bit typed,
                            head_rpt_t want);
        head_rpt_t             pred;
        logic [IN_TDATA_W-1:0] word;
        int                    gap;
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word = '0;
        word[IN_ID_LSB +: ID_W]       = id;
        word[IN_STAMP_LSB +: STAMP_W] = stamp;
        word[IN_MORE_BIT]             = more;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        pred = order_step(cmd, id, stamp, more);
        head_expect_q.push_back(typed ? want : pred);
    endtask

    function automatic logic [STAMP_W-1:0] pick_stamp(int mode);
        case (mode)
            0:       return STAMP_W'($urandom_range(0, 7));
            1:       return $urandom;
            default: return ($urandom_range(0, 1) ? 32'hFFFF_FFF8 : 32'h0)
                            + STAMP_W'($urandom_range(0, 7));
        endcase
    endfunction

    always @(posedge clk)
    begin
        head_rpt_t got;
        head_rpt_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.valid  = m_tdata[OUT_VALID_BIT];
            got.source = m_tdata[OUT_ID_LSB +: ID_W];
            got.stamp  = m_tdata[OUT_STAMP_LSB +: STAMP_W];
            got.occ    = m_tdata[OUT_OCC_LSB +: OCC_W];
            got.status = kwmoq_pkg::status_t'(m_tdata[OUT_STATUS_LSB +: STATUS_W]);
            n_results++;
            if (head_expect_q.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: v=%0d src=%0d stamp=%h occ=%0d st=%0d",
                             got.valid, got.source, got.stamp, got.occ, got.status);
            end
            else
            begin
                want = head_expect_q.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch at result %0d: exp v=%0d src=%0d stamp=%h occ=%0d st=%0d",
                                 n_results, want.valid, want.source, want.stamp, want.occ,
                                 want.status);
                        $display("    got v=%0d src=%0d stamp=%h occ=%0d st=%0d",
                                 got.valid, got.source, got.stamp, got.occ, got.status);
                    end
                end
            end
        end
        if (idling_on && stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 13);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("** k_way_merge_ordering_queue_core: FAILED **");
        $finish;
    end

    initial
    begin
        int              sent;
        int              phase_len;
        int              ins_pct;
        int              stamp_mode;
        kwmoq_pkg::cmd_t cmd;
        head_rpt_t       none;
        none = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(kwmoq_pkg::CMD_ADVANCE, 4'd9, 32'hFFFF_FFFF, 1'b1, 1'b1,
                head_rpt_t'{1'b0, 4'd0, 32'd0, 5'd0, kwmoq_pkg::ST_EMPTY});
        add_row(kwmoq_pkg::CMD_INSERT, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1,
                head_rpt_t'{1'b1, 4'd15, 32'hFFFF_FFFF, 5'd1, kwmoq_pkg::ST_DONE});
        add_row(kwmoq_pkg::CMD_INSERT, 4'd0, 32'd0, 1'b0, 1'b1,
                head_rpt_t'{1'b1, 4'd0, 32'd0, 5'd2, kwmoq_pkg::ST_DONE});
        add_row(kwmoq_pkg::CMD_INSERT, 4'd5, 32'd0, 1'b1, 1'b1,
                head_rpt_t'{1'b1, 4'd0, 32'd0, 5'd3, kwmoq_pkg::ST_DONE});
        add_row(kwmoq_pkg::CMD_ADVANCE, 4'd12, 32'hFFFF_FFFF, 1'b1, 1'b0, none);
        add_row(kwmoq_pkg::CMD_ADVANCE, 4'd3, 32'h8000_0000, 1'b0, 1'b0, none);
        for (int i = 1; i <= 14; i++)
            add_row(kwmoq_pkg::CMD_INSERT, ID_W'(i),
                    (i % 3 == 0) ? 32'h7FFF_FFFF : $urandom, 1'(i), 1'b0, none);
        add_row(kwmoq_pkg::CMD_INSERT, 4'd7, 32'd1, 1'b0, 1'b0, none);
        add_row(kwmoq_pkg::CMD_ADVANCE, 4'd0, 32'h8000_0000, 1'b1, 1'b0, none);
        add_row(kwmoq_pkg::CMD_INSERT, 4'd15, 32'd0, 1'b1, 1'b0, none);

        foreach (stim_rows[i])
            send_cmd(stim_rows[i].cmd, stim_rows[i].id, stim_rows[i].stamp,
                     stim_rows[i].more, stim_rows[i].typed, stim_rows[i].want);

        sent = 0;
        while (sent < 1150)
        begin
            if (sent >= 1030)
            begin
                idling_on  = 1'b0;
                phase_len  = 1150 - sent;
                ins_pct    = 50;
                stamp_mode = 1;
            end
            else
            begin
                idling_on  = ($urandom_range(0, 3) != 0);
                phase_len  = $urandom_range(30, 80);
                case ($urandom_range(0, 3))
                    0:       ins_pct = 20;
                    1:       ins_pct = 50;
                    2:       ins_pct = 80;
                    default: ins_pct = 95;
                endcase
                stamp_mode = $urandom_range(0, 2);
            end
            repeat (phase_len)
            begin
                cmd = ($urandom_range(1, 100) <= ins_pct) ? kwmoq_pkg::CMD_INSERT
                                                           : kwmoq_pkg::CMD_ADVANCE;
                send_cmd(cmd, ID_W'($urandom_range(0, 15)), pick_stamp(stamp_mode),
                         1'($urandom_range(0, 3) != 0), 1'b0, none);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (head_expect_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d commands: %0d inserts, %0d dropped full, %0d advances, %0d on empty",
                 n_insert + n_advance, n_insert, n_full_drop, n_advance, n_empty_adv);
        $display("checked %0d results, %0d mismatches", n_results, mismatch_count);
        if (fail_count == 0)
            $display("** k_way_merge_ordering_queue_core: PASSED **");
        else
            $display("** k_way_merge_ordering_queue_core: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/kwmoq_pkg.sv
hw/rtl/kwmoq_ctrl.sv
hw/rtl/kwmoq_dpath.sv
hw/rtl/k_way_merge_ordering_queue_core.sv
hw/rtl/kwmoq_checker.sv
sim/tb.sv
